@@ hdl/tmf_pkg.sv @@
`timescale 1ns / 1ps

package tmf_pkg;

    localparam int MAX_PADDED_WIDTH_DEF = 1024;
    localparam int PIX_W      = 8;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 17;
    localparam int WIDTH_W    = 10;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int LINES      = 4;
    localparam int WIN        = 5;
    localparam int LINE_W     = LINES * PIX_W;
    localparam int ROW_SUM_W  = 11;
    localparam int SUM_W      = 13;
    localparam int RECIP_W    = 13;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);

    // floor(x / 23) = (x * 5699) >> 17 for x below 8192
    localparam logic [RECIP_W-1:0] RECIP_23  = RECIP_W'(5699);
    localparam int                 RECIP_SHIFT = 17;
    localparam logic [PIX_W-1:0]   PIX_MAX   = '1;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic produce;
        logic last;
    } t_flags;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

@@ hdl/tmf_fifo.sv @@
`timescale 1ns / 1ps

module tmf_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = tmf_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output tmf_pkg::t_fifo_stat o_stat
);
    import tmf_pkg::*;

    localparam int PW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

@@ hdl/tmf_front.sv @@
`timescale 1ns / 1ps

module tmf_front #(
    parameter int MAX_PADDED_WIDTH = tmf_pkg::MAX_PADDED_WIDTH_DEF,
    localparam int AW = $clog2(MAX_PADDED_WIDTH)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  tmf_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [tmf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_tvalid,
    output logic                              o_tready,
    input  logic [tmf_pkg::PIX_W-1:0]         i_px,
    input  logic                              i_full,
    output logic                              o_push,
    output logic [tmf_pkg::PIX_W-1:0]         o_px,
    output logic [AW-1:0]                     o_addr,
    output tmf_pkg::t_flags                   o_flags
);
    import tmf_pkg::*;

    localparam int PW_W = $clog2(MAX_PADDED_WIDTH + 1);
    localparam int EW   = (PW_W > COL_W + 1) ? PW_W : COL_W + 1;
    localparam logic [EW-1:0] MAX_E = EW'(MAX_PADDED_WIDTH);

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    n_col;
    logic [ROW_W-1:0]    n_row;

    logic [EW-1:0]    w_width_p4;
    logic [EW-1:0]    w_pw;
    logic [EW-1:0]    w_col_e;
    logic [EW-1:0]    w_col_clamp;
    logic [ROW_W-1:0] w_ph;
    logic             w_row_end;
    logic             w_frame_end;

    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;

    assign w_width_p4  = EW'(r_width) + EW'(4);
    assign w_pw        = (w_width_p4 > MAX_E) ? MAX_E : w_width_p4;
    assign w_col_e     = EW'(r_col);
    assign w_col_clamp = (w_col_e >= MAX_E) ? (MAX_E - EW'(1)) : w_col_e;
    assign w_ph        = ROW_W'(r_height) + ROW_W'(4);
    assign w_row_end   = (w_col_e >= w_pw - EW'(1));
    assign w_frame_end = w_row_end && (r_row >= w_ph - ROW_W'(1));

    assign o_px            = i_px;
    assign o_addr          = w_col_clamp[AW-1:0];
    assign o_flags.produce = (r_col >= COL_W'(4)) && (r_row >= ROW_W'(4));
    assign o_flags.last    = w_frame_end;

    always_comb begin
        n_col = r_col + COL_W'(1);
        n_row = r_row;
        if (w_row_end) begin
            n_col = '0;
            n_row = w_frame_end ? '0 : r_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH: begin
                        r_width <= i_cfg_data[WIDTH_W-1:0];
                    end
                    CFG_IMAGE_HEIGHT: begin
                        r_height <= i_cfg_data[HEIGHT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (o_push) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

endmodule

@@ hdl/tmf_back.sv @@
`timescale 1ns / 1ps

module tmf_back #(
    parameter int MAX_PADDED_WIDTH = tmf_pkg::MAX_PADDED_WIDTH_DEF,
    localparam int AW = $clog2(MAX_PADDED_WIDTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    output logic                      o_pop,
    input  logic [tmf_pkg::PIX_W-1:0] i_px,
    input  logic [AW-1:0]             i_addr,
    input  tmf_pkg::t_flags           i_flags,
    output logic                      o_tvalid,
    input  logic                      i_tready,
    output logic [tmf_pkg::PIX_W-1:0] o_mean,
    output logic                      o_last
);
    import tmf_pkg::*;

    logic w_adv;

    // line store: four previous rows packed per column, oldest in the low byte
    logic [LINE_W-1:0] r_mem [MAX_PADDED_WIDTH];
    logic [LINE_W-1:0] r_rd;
    logic              r_fwd;
    logic [LINE_W-1:0] r_fwd_data;
    logic [LINE_W-1:0] w_col_word;
    logic [LINE_W-1:0] n_line_word;

    logic             r_a_valid;
    logic [PIX_W-1:0] r_a_px;
    logic [AW-1:0]    r_a_addr;
    t_flags           r_a_flags;

    logic [PIX_W-1:0] r_win [WIN][WIN];
    logic [PIX_W-1:0] w_column [WIN];
    logic             r_b_valid;
    t_flags           r_b_flags;

    logic [ROW_SUM_W-1:0] n_c_sum [WIN];
    logic [PIX_W-1:0]     n_c_min [WIN];
    logic [PIX_W-1:0]     n_c_max [WIN];
    logic [ROW_SUM_W-1:0] r_c_sum [WIN];
    logic [PIX_W-1:0]     r_c_min [WIN];
    logic [PIX_W-1:0]     r_c_max [WIN];
    logic                 r_c_valid;
    t_flags               r_c_flags;

    logic [SUM_W-1:0] n_d_sum;
    logic [PIX_W-1:0] n_d_min;
    logic [PIX_W-1:0] n_d_max;
    logic [SUM_W-1:0] r_d_sum;
    logic [PIX_W-1:0] r_d_min;
    logic [PIX_W-1:0] r_d_max;
    logic             r_d_valid;
    t_flags           r_d_flags;

    logic [SUM_W-1:0] r_e_x;
    logic             r_e_valid;
    t_flags           r_e_flags;

    logic [PROD_W-1:0] r_f_prod;
    logic              r_f_valid;
    t_flags            r_f_flags;

    logic [PROD_W-RECIP_SHIFT-1:0] w_quot;
    logic [PIX_W-1:0]              n_mean;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_mean;
    logic             r_out_last;

    assign w_adv = !r_out_valid || i_tready;
    assign o_pop = w_adv && !i_empty;

    assign w_col_word  = r_fwd ? r_fwd_data : r_rd;
    assign n_line_word = {r_a_px, w_col_word[LINE_W-1:PIX_W]};

    always_comb begin
        for (int r = 0; r < LINES; r++) begin
            w_column[r] = w_col_word[r*PIX_W +: PIX_W];
        end
        w_column[WIN-1] = r_a_px;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rd <= r_mem[i_addr];
            if (r_a_valid) begin
                r_mem[r_a_addr] <= n_line_word;
            end
        end
    end

    always_comb begin
        for (int r = 0; r < WIN; r++) begin
            n_c_sum[r] = '0;
            n_c_min[r] = PIX_MAX;
            n_c_max[r] = '0;
            for (int c = 0; c < WIN; c++) begin
                n_c_sum[r] = n_c_sum[r] + ROW_SUM_W'(r_win[r][c]);
                if (r_win[r][c] < n_c_min[r]) begin
                    n_c_min[r] = r_win[r][c];
                end
                if (r_win[r][c] > n_c_max[r]) begin
                    n_c_max[r] = r_win[r][c];
                end
            end
        end
    end

    always_comb begin
        n_d_sum = '0;
        n_d_min = PIX_MAX;
        n_d_max = '0;
        for (int r = 0; r < WIN; r++) begin
            n_d_sum = n_d_sum + SUM_W'(r_c_sum[r]);
            if (r_c_min[r] < n_d_min) begin
                n_d_min = r_c_min[r];
            end
            if (r_c_max[r] > n_d_max) begin
                n_d_max = r_c_max[r];
            end
        end
    end

    assign w_quot = r_f_prod[PROD_W-1:RECIP_SHIFT];
    assign n_mean = (w_quot > (PROD_W-RECIP_SHIFT)'(PIX_MAX)) ? PIX_MAX : w_quot[PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd       <= 1'b0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_e_valid   <= 1'b0;
            r_f_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int r = 0; r < WIN; r++) begin
                for (int c = 0; c < WIN; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (w_adv) begin
            // same column written back in the edge it is read again
            r_fwd       <= r_a_valid && (i_addr == r_a_addr);
            r_a_valid   <= o_pop;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_d_valid   <= r_c_valid;
            r_e_valid   <= r_d_valid;
            r_f_valid   <= r_e_valid;
            r_out_valid <= r_f_valid && r_f_flags.produce;
            if (r_a_valid) begin
                for (int r = 0; r < WIN; r++) begin
                    for (int c = 0; c < WIN - 1; c++) begin
                        r_win[r][c] <= r_win[r][c+1];
                    end
                    r_win[r][WIN-1] <= w_column[r];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fwd_data <= n_line_word;
            r_a_px     <= i_px;
            r_a_addr   <= i_addr;
            r_a_flags  <= i_flags;
            r_b_flags  <= r_a_flags;
            r_c_flags  <= r_b_flags;
            r_c_sum    <= n_c_sum;
            r_c_min    <= n_c_min;
            r_c_max    <= n_c_max;
            r_d_flags  <= r_c_flags;
            r_d_sum    <= n_d_sum;
            r_d_min    <= n_d_min;
            r_d_max    <= n_d_max;
            r_e_flags  <= r_d_flags;
            r_e_x      <= r_d_sum - SUM_W'(r_d_min) - SUM_W'(r_d_max);
            r_f_flags  <= r_e_flags;
            r_f_prod   <= PROD_W'(r_e_x) * PROD_W'(RECIP_23);
            r_out_mean <= n_mean;
            r_out_last <= r_f_flags.last;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_mean   = r_out_mean;
    assign o_last   = r_out_last;

endmodule

@@ hdl/trimmed_mean_5x5_filter_core.sv @@
`timescale 1ns / 1ps
// throughput: one item per cycle while m_axis_tready stays high
// the back end pipeline and line store port advance only when the output register is free
// reset: synchronous active low; clears counters, window, queue, pipeline valids and config
// to 640 x 480; the line store is not cleared

module trimmed_mean_5x5_filter_core #(
    parameter int MAX_PADDED_WIDTH = tmf_pkg::MAX_PADDED_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  tmf_pkg::t_cfg_idx              i_cfg_index,
    input  logic [tmf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] pixel
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // [7:0] mean_value
    output logic                           m_axis_tlast
);
    import tmf_pkg::*;

    localparam int AW     = $clog2(MAX_PADDED_WIDTH);
    localparam int ITEM_W = PIX_W + AW + $bits(t_flags);

    logic             w_push;
    logic [PIX_W-1:0] w_front_px;
    logic [AW-1:0]    w_front_addr;
    t_flags           w_front_flags;
    t_fifo_stat       w_fifo_stat;
    logic             w_pop;
    logic [ITEM_W-1:0] w_q_data;
    logic [PIX_W-1:0] w_back_px;
    logic [AW-1:0]    w_back_addr;
    t_flags           w_back_flags;

    tmf_front #(
        .MAX_PADDED_WIDTH(MAX_PADDED_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_tvalid   (s_axis_tvalid),
        .o_tready   (s_axis_tready),
        .i_px       (s_axis_tdata),
        .i_full     (w_fifo_stat.full),
        .o_push     (w_push),
        .o_px       (w_front_px),
        .o_addr     (w_front_addr),
        .o_flags    (w_front_flags)
    );

    tmf_fifo #(
        .DATA_W(ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data ({w_front_flags, w_front_addr, w_front_px}),
        .i_pop  (w_pop),
        .o_data (w_q_data),
        .o_stat (w_fifo_stat)
    );

    assign w_back_px    = w_q_data[PIX_W-1:0];
    assign w_back_addr  = w_q_data[PIX_W +: AW];
    assign w_back_flags = w_q_data[ITEM_W-1 -: $bits(t_flags)];

    tmf_back #(
        .MAX_PADDED_WIDTH(MAX_PADDED_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_fifo_stat.empty),
        .o_pop   (w_pop),
        .i_px    (w_back_px),
        .i_addr  (w_back_addr),
        .i_flags (w_back_flags),
        .o_tvalid(m_axis_tvalid),
        .i_tready(m_axis_tready),
        .o_mean  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fifo_stat.empty)
        else $error("queue popped while empty");

    a_back_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_fifo_stat.empty && !m_axis_tvalid) |-> w_pop)
        else $error("back end idle with a queued item and a free output");

    a_stall_holds_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !w_pop)
        else $error("back end advanced while output stalled");

endmodule

@@ verif/tb_trimmed_mean_5x5_filter_core.sv @@
`timescale 1ns / 1ps

module tb_trimmed_mean_5x5_filter_core;
    import tmf_pkg::*;

    localparam int CLK_HALF_NS   = 1;
    localparam int RST_CYCLES    = 12;
    localparam int SETTLE_CYCLES = 20;
    localparam int TIMEOUT_NS    = 2000000;
    localparam int RANDOM_PIXELS = 900;
    localparam int CALM_PIXELS   = 300;
    localparam int TRIM_DIV      = 23;
    localparam int MAX_PRINTS    = 100;

    typedef struct {
        logic [PIX_W-1:0] mean;
        logic             last;
    } t_mean_item;

    typedef enum int {
        PIX_UNIFORM,
        PIX_BINARY,
        PIX_BRIGHT,
        PIX_DARK,
        PIX_SATURATED
    } t_pix_style;

    class t_trimmed_mean_tracker;
        int unsigned      img_width;
        int unsigned      img_height;
        logic [PIX_W-1:0] line_mem [LINES][MAX_PADDED_WIDTH_DEF];
        logic [PIX_W-1:0] win [WIN][WIN];
        int unsigned      col_cnt;
        int unsigned      row_cnt;
        t_mean_item       pending_means [$];
        int unsigned      mismatches;

        function new();
            img_width  = 32'(WIDTH_RST);
            img_height = 32'(HEIGHT_RST);
            col_cnt    = 0;
            row_cnt    = 0;
            mismatches = 0;
            foreach (line_mem[r, c]) line_mem[r][c] = '0;
            foreach (win[r, c]) win[r][c] = '0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH: img_width = 32'(data[WIDTH_W-1:0]);
                CFG_IMAGE_HEIGHT: img_height = 32'(data[HEIGHT_W-1:0]);
                default: ;
            endcase
        endfunction

        function logic [PIX_W-1:0] window_trimmed_mean();
            int unsigned sum;
            int unsigned lo;
            int unsigned hi;
            sum = 0;
            lo  = 32'(PIX_MAX);
            hi  = 0;
            foreach (win[r, c]) begin
                sum += 32'(win[r][c]);
                if (32'(win[r][c]) > hi) hi = 32'(win[r][c]);
                if (32'(win[r][c]) < lo) lo = 32'(win[r][c]);
            end
            sum = (sum - lo - hi) / TRIM_DIV;
            if (sum > 32'(PIX_MAX)) sum = 32'(PIX_MAX);
            return sum[PIX_W-1:0];
        endfunction

        function void take_pixel(logic [PIX_W-1:0] px);
            int unsigned      pad_w;
            int unsigned      pad_h;
            logic [PIX_W-1:0] column [WIN];
            bit               row_end;
            bit               frame_end;
            t_mean_item       item;
            pad_w = img_width + 4;
            if (pad_w > MAX_PADDED_WIDTH_DEF) pad_w = MAX_PADDED_WIDTH_DEF;
            pad_h = img_height + 4;

            for (int r = 0; r < LINES; r++) column[r] = line_mem[r][col_cnt];
            column[LINES] = px;
            for (int r = 0; r < LINES; r++) line_mem[r][col_cnt] = column[r+1];
            for (int r = 0; r < WIN; r++) begin
                for (int c = 0; c < WIN - 1; c++) win[r][c] = win[r][c+1];
                win[r][WIN-1] = column[r];
            end

            row_end   = col_cnt >= pad_w - 1;
            frame_end = row_end && row_cnt >= pad_h - 1;
            if (col_cnt >= 4 && row_cnt >= 4) begin
                item.mean = window_trimmed_mean();
                item.last = frame_end;
                pending_means.push_back(item);
            end
            if (row_end) begin
                col_cnt = 0;
                row_cnt = frame_end ? 0 : (row_cnt + 1) & ((1 << ROW_W) - 1);
            end else begin
                col_cnt = (col_cnt + 1) & ((1 << COL_W) - 1);
            end
        endfunction

        function bit at_frame_start();
            return col_cnt == 0 && row_cnt == 0;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_mean(logic [PIX_W-1:0] mean, logic last);
            t_mean_item want;
            if (pending_means.size() == 0) begin
                report_mismatch($sformatf("unexpected item mean=%0d last=%0b", mean, last));
                return;
            end
            want = pending_means.pop_front();
            if (mean !== want.mean)
                report_mismatch($sformatf("mean got %0d want %0d", mean, want.mean));
            if (last !== want.last)
                report_mismatch($sformatf("tlast got %0b want %0b", last, want.last));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    t_cfg_idx              i_cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;   // [7:0] pixel
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;        // [7:0] mean_value
    logic                  m_axis_tlast;

    t_trimmed_mean_tracker tracker = new();
    int                    in_idle_pct = 33;
    int                    out_idle_pct = 33;
    int unsigned           pixels_sent = 0;

    trimmed_mean_5x5_filter_core dut (.*);

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_mean(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= ($urandom_range(99) >= out_idle_pct);
    end

    function automatic logic [PIX_W-1:0] pick_pixel(t_pix_style style);
        case (style)
            PIX_BINARY: return $urandom_range(0, 1) ? PIX_MAX : '0;
            PIX_BRIGHT: return PIX_W'($urandom_range(240, 255));
            PIX_DARK: return PIX_W'($urandom_range(0, 15));
            PIX_SATURATED: return PIX_MAX;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixel(logic [PIX_W-1:0] px);
        while ($urandom_range(99) < in_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_pixel(px);
        pixels_sent++;
    endtask

    task automatic run_pixels(int unsigned n, t_pix_style style);
        repeat (n) push_pixel(pick_pixel(style));
    endtask

    task automatic run_frame(t_pix_style style);
        do push_pixel(pick_pixel(style)); while (!tracker.at_frame_start());
    endtask

    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_size(logic [CFG_DATA_W-1:0] width_data,
                            logic [CFG_DATA_W-1:0] height_data);
        wait_results_done();
        write_cfg(CFG_IMAGE_WIDTH, width_data);
        write_cfg(CFG_IMAGE_HEIGHT, height_data);
    endtask

    initial begin
        #TIMEOUT_NS;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int unsigned start_count;
        int unsigned pick;
        logic [WIDTH_W-1:0] new_width;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry, then shrink width and height partway through the frame
        run_pixels(30, PIX_UNIFORM);
        wait_results_done();
        write_cfg(CFG_IMAGE_WIDTH, 16'hfc03);
        run_pixels(12, PIX_UNIFORM);
        wait_results_done();
        write_cfg(CFG_IMAGE_HEIGHT, 16'd1);
        run_frame(PIX_UNIFORM);

        // smallest frame at full scale
        set_size(16'd1, 16'd1);
        run_frame(PIX_SATURATED);

        // frames too narrow or too short to give any item
        set_size(16'd0, 16'd1);
        run_frame(PIX_UNIFORM);
        set_size(16'd1, 16'd0);
        run_frame(PIX_UNIFORM);

        // tallest frame, cut short by a height write
        set_size(16'd1, 16'hffff);
        run_pixels(50, PIX_BINARY);
        wait_results_done();
        write_cfg(CFG_IMAGE_HEIGHT, 16'd3);
        run_frame(PIX_BINARY);

        // width that saturates, cut short by a width write
        set_size(16'h03ff, 16'd1);
        run_pixels(20, PIX_BRIGHT);
        wait_results_done();
        write_cfg(CFG_IMAGE_WIDTH, 16'd2);
        run_frame(PIX_BRIGHT);

        // random frames; a calm stretch first
        in_idle_pct  = 0;
        out_idle_pct = 0;
        start_count  = pixels_sent;
        while (pixels_sent - start_count < RANDOM_PIXELS) begin
            if (pixels_sent - start_count >= CALM_PIXELS) begin
                in_idle_pct  = 33;
                out_idle_pct = 33;
            end
            if ($urandom_range(0, 2) != 0) begin
                pick = $urandom_range(99);
                if (pick < 80)
                    new_width = WIDTH_W'($urandom_range(1, 16));
                else if (pick < 97)
                    new_width = WIDTH_W'($urandom_range(17, 40));
                else
                    new_width = '0;
                set_size({6'($urandom_range(0, 63)), new_width},
                         CFG_DATA_W'($urandom_range(0, 10)));
            end
            run_frame(t_pix_style'($urandom_range(0, 3)));
        end

        wait_results_done();
        if (tracker.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/tmf_pkg.sv
hdl/tmf_fifo.sv
hdl/tmf_front.sv
hdl/tmf_back.sv
hdl/trimmed_mean_5x5_filter_core.sv
verif/tb_trimmed_mean_5x5_filter_core.sv
